@@ hdl/bps_pkg.sv @@
package bps_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int BUFFER_MAX    = 65536;
    localparam int PAT_REG_BYTES = 16;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 16;
    localparam int LEN_W       = 5;
    localparam int SEEN_W      = $clog2(BUFFER_MAX + 1);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int PAT_W       = PAT_REG_BYTES * BYTE_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_t;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  base_offset;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  start;
    } match_t;

    typedef struct packed {
        logic              emit;
        logic              found;
        logic [POS_W-1:0]  match_position;
    } result_t;

    function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pattern,
                                                   input int j);
        logic [BYTE_W-1:0] b;
        b = '0;
        if (j < PAT_REG_BYTES)
        begin
            b = pattern[BYTE_W*j +: BYTE_W];
        end
        return b;
    endfunction

endpackage

@@ hdl/byte_pattern_search.sv @@
// Byte pattern search: streams buffer bytes one per transfer and reports the first position
// where the configured pattern (0 to 16 bytes, pattern_length) occurs in full. Each stream
// produces exactly one result: at the first match, found set and position equal to the base
// offset of the stream's first transfer plus the match start (modulo 2^16), or at the transfer
// with tlast when no match occurred, found clear and position zero. Bytes after a match are
// dropped until tlast; only the first 65536 bytes of a stream are searched. A zero-length
// pattern matches at the first byte. Throughput is one byte per clock cycle while no earlier
// result waits on m_axis_tready, set by the combinational parallel compare of the 16-byte
// window against every pattern length; each transfer is held in an input register and its
// result is registered into the output registers. Write configuration only while idle.
module byte_pattern_search
    import bps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [23:0]            s_axis_tdata,   // data_byte[7:0], base_offset[23:8]
    input  logic                   s_axis_tlast,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // match_position[15:0]
    output logic [0:0]             m_axis_tuser    // found[0]
);

    cfg_t             cfg;
    item_t            item_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic             advance;
    result_t          result;

    bps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.data_byte   <= s_axis_tdata[BYTE_W-1:0];
            item_reg.base_offset <= s_axis_tdata[BYTE_W +: POS_W];
            item_reg.last_byte   <= s_axis_tlast;
        end
    end

    bps_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_found_reg <= result.found;
            out_pos_reg   <= result.match_position;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_pos_reg;
    assign m_axis_tuser[0] = out_found_reg;

endmodule

@@ hdl/bps_cfg.sv @@
module bps_cfg
    import bps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            length_reg   <= LEN_W'(1);
        end
        else if (cfg_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                CFG_PATTERN_LENGTH: length_reg   <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.length  = length_reg;

endmodule

@@ hdl/bps_match.sv @@
module bps_match
    import bps_pkg::*;
(
    input  window_t           window,
    input  logic [SEEN_W-1:0] seen,
    input  cfg_t              cfg,
    output match_t            match
);

    logic [PATTERN_MAX:0] match_vec;
    logic                 sel;
    logic                 len_ok;
    logic                 enough;
    logic [SEEN_W-1:0]    start_full;

    always_comb
    begin
        for (int l = 0; l <= PATTERN_MAX; l++)
        begin
            match_vec[l] = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (window[j] != pat_byte(cfg.pattern, l - 1 - j))
                begin
                    match_vec[l] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        sel = 1'b0;
        for (int l = 0; l <= PATTERN_MAX; l++)
        begin
            if (cfg.length == LEN_W'(l))
            begin
                sel = match_vec[l];
            end
        end
    end

    assign len_ok = (cfg.length <= LEN_W'(PAT_REG_BYTES));
    assign enough = (seen >= SEEN_W'(cfg.length));

    assign start_full  = (cfg.length == '0) ? '0 : seen - SEEN_W'(cfg.length);
    assign match.hit   = sel && len_ok && enough;
    assign match.start = start_full[POS_W-1:0];

endmodule

@@ hdl/bps_track.sv @@
module bps_track
    import bps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    window_t           win_reg;
    window_t           win_next;
    window_t           win_shift;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [SEEN_W-1:0] seen_inc;
    logic              reported_reg;
    logic              reported_next;
    logic [POS_W-1:0]  held_reg;
    logic [POS_W-1:0]  held_next;

    logic              first;
    logic              scan;
    logic              hit_now;
    logic [POS_W-1:0]  base_eff;
    match_t            match;

    assign first    = (seen_reg == '0) && !reported_reg;
    assign base_eff = first ? item.base_offset : held_reg;
    assign scan     = !reported_reg && (seen_reg < SEEN_W'(BUFFER_MAX));
    assign seen_inc = seen_reg + SEEN_W'(1);

    always_comb
    begin
        win_shift[0] = item.data_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_shift[k] = win_reg[k-1];
        end
    end

    bps_match u_match (
        .window (win_shift),
        .seen   (seen_inc),
        .cfg    (cfg),
        .match  (match)
    );

    assign hit_now = scan && match.hit;

    assign result.emit           = step && (hit_now || (item.last_byte && !reported_reg));
    assign result.found          = hit_now;
    assign result.match_position = hit_now ? (base_eff + match.start) : '0;

    always_comb
    begin
        win_next      = win_reg;
        seen_next     = seen_reg;
        reported_next = reported_reg;
        held_next     = held_reg;
        if (step)
        begin
            if (item.last_byte)
            begin
                win_next      = '0;
                seen_next     = '0;
                reported_next = 1'b0;
                held_next     = '0;
            end
            else
            begin
                held_next = base_eff;
                if (scan)
                begin
                    win_next  = win_shift;
                    seen_next = seen_inc;
                end
                if (hit_now)
                begin
                    reported_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
            held_reg     <= '0;
        end
        else
        begin
            win_reg      <= win_next;
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
            held_reg     <= held_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |-> step)
        else $error("result emitted without an item");

    a_miss_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit && !result.found |-> item.last_byte && !reported_reg)
        else $error("miss reported before end of stream");

    a_hit_sets_reported: assert property (@(posedge clk) disable iff (!rst_n)
        step && hit_now && !item.last_byte |=> reported_reg && !result.found)
        else $error("second match reported in one stream");

    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(BUFFER_MAX))
        else $error("byte count beyond buffer limit");
`endif

endmodule
